### design/fsp_pkg.sv
// Shared types, codes and character helpers for the FASTA stream parser.
package fsp_pkg;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_HDR_BYTE = 3'd1,
        KIND_BASE     = 3'd2,
        KIND_HDR_END  = 3'd3,
        KIND_REC_END  = 3'd4,
        KIND_OK       = 3'd5,
        KIND_ERROR    = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ERR_DOUBLE_HEADER  = 2'd0,
        ERR_MISSING_HEADER = 2'd1,
        ERR_BAD_SYMBOL     = 2'd2,
        ERR_MISSING_SEQ    = 2'd3
    } t_err;

    localparam logic [7:0] CHAR_GT      = 8'h3E;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam int INDEX_BITS = 16;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              data_byte;
        t_err                    error_code;
        logic [INDEX_BITS-1:0]   record_index;
    } t_out_item;

    function automatic logic is_base(input logic [7:0] c);
        logic upper;
        logic lower;
        upper = (c >= 8'h41) && (c <= 8'h5A);
        lower = (c >= 8'h61) && (c <= 8'h7A);
        return upper || lower || (c == CHAR_DASH);
    endfunction

endpackage

### design/fsp_core.sv
// Parser flags, record counter and per-byte classification.
module fsp_core #(
    parameter int RECORD_COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  fsp_pkg::t_in_item  i_item,
    output fsp_pkg::t_out_item o_result
);

    logic                         r_at_line_start;
    logic                         r_header_pending;
    logic                         r_in_sequence;
    logic                         r_in_comment;
    logic                         r_error_seen;
    logic [RECORD_COUNT_BITS-1:0] r_count;

    logic                         n_at_line_start;
    logic                         n_header_pending;
    logic                         n_in_sequence;
    logic                         n_in_comment;
    logic                         n_error_seen;
    logic [RECORD_COUNT_BITS-1:0] n_count;

    logic [31:0] count_ext;
    logic [7:0]  c;
    logic        nl;
    logic        base;

    assign count_ext = 32'(r_count);
    assign c         = i_item.char_byte;
    assign nl        = (c == fsp_pkg::CHAR_NEWLINE);
    assign base      = fsp_pkg::is_base(c);

    always_comb begin
        n_at_line_start  = r_at_line_start;
        n_header_pending = r_header_pending;
        n_in_sequence    = r_in_sequence;
        n_in_comment     = r_in_comment;
        n_error_seen     = r_error_seen;
        n_count          = r_count;
        o_result.kind         = fsp_pkg::KIND_NONE;
        o_result.data_byte    = 8'd0;
        o_result.error_code   = fsp_pkg::ERR_DOUBLE_HEADER;
        o_result.record_index = count_ext[fsp_pkg::INDEX_BITS-1:0];

        if (i_item.end_of_stream) begin
            if (!r_error_seen) begin
                if (r_header_pending || !r_in_sequence) begin
                    o_result.kind       = fsp_pkg::KIND_ERROR;
                    o_result.error_code = fsp_pkg::ERR_MISSING_SEQ;
                end else begin
                    o_result.kind = fsp_pkg::KIND_OK;
                end
            end
            n_at_line_start  = 1'b1;
            n_header_pending = 1'b0;
            n_in_sequence    = 1'b0;
            n_in_comment     = 1'b0;
            n_error_seen     = 1'b0;
            n_count          = '0;
        end else if (r_error_seen) begin
            o_result.kind = fsp_pkg::KIND_NONE;
        end else if (r_at_line_start) begin
            n_at_line_start = nl;
            if (c == fsp_pkg::CHAR_GT) begin
                if (r_header_pending) begin
                    o_result.kind       = fsp_pkg::KIND_ERROR;
                    o_result.error_code = fsp_pkg::ERR_DOUBLE_HEADER;
                    o_result.data_byte  = c;
                    n_error_seen        = 1'b1;
                end else begin
                    n_header_pending = 1'b1;
                    if (r_in_sequence) begin
                        o_result.kind = fsp_pkg::KIND_REC_END;
                        n_in_sequence = 1'b0;
                        // saturate at all ones
                        if (r_count != '1) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
            end else if (c == fsp_pkg::CHAR_HASH) begin
                n_in_comment = 1'b1;
            end else if (base) begin
                if (r_in_sequence) begin
                    o_result.kind      = fsp_pkg::KIND_BASE;
                    o_result.data_byte = c;
                end else if (!r_header_pending) begin
                    o_result.kind       = fsp_pkg::KIND_ERROR;
                    o_result.error_code = fsp_pkg::ERR_MISSING_HEADER;
                    o_result.data_byte  = c;
                    n_error_seen        = 1'b1;
                end else begin
                    n_in_sequence      = 1'b1;
                    n_header_pending   = 1'b0;
                    o_result.kind      = fsp_pkg::KIND_BASE;
                    o_result.data_byte = c;
                end
            end else if (!nl) begin
                o_result.kind       = fsp_pkg::KIND_ERROR;
                o_result.error_code = fsp_pkg::ERR_BAD_SYMBOL;
                o_result.data_byte  = c;
                n_error_seen        = 1'b1;
            end
        end else begin
            n_at_line_start = nl;
            if (r_in_comment) begin
                if (nl) begin
                    n_in_comment = 1'b0;
                end
            end else if (r_header_pending) begin
                if (nl) begin
                    o_result.kind = fsp_pkg::KIND_HDR_END;
                end else begin
                    o_result.kind      = fsp_pkg::KIND_HDR_BYTE;
                    o_result.data_byte = c;
                end
            end else if (r_in_sequence) begin
                if (base) begin
                    o_result.kind      = fsp_pkg::KIND_BASE;
                    o_result.data_byte = c;
                end else if (!nl) begin
                    o_result.kind       = fsp_pkg::KIND_ERROR;
                    o_result.error_code = fsp_pkg::ERR_BAD_SYMBOL;
                    o_result.data_byte  = c;
                    n_error_seen        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start  <= 1'b1;
            r_header_pending <= 1'b0;
            r_in_sequence    <= 1'b0;
            r_in_comment     <= 1'b0;
            r_error_seen     <= 1'b0;
            r_count          <= '0;
        end else if (i_fire) begin
            r_at_line_start  <= n_at_line_start;
            r_header_pending <= n_header_pending;
            r_in_sequence    <= n_in_sequence;
            r_in_comment     <= n_in_comment;
            r_error_seen     <= n_error_seen;
            r_count          <= n_count;
        end
    end

    a_hdr_seq_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_header_pending && r_in_sequence))
        else $error("header pending and sequence active at once");

    a_eos_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.end_of_stream |=>
            r_at_line_start && !r_header_pending && !r_in_sequence &&
            !r_in_comment && !r_error_seen && (r_count == '0))
        else $error("end of stream did not reinitialize parser");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error_seen && !(i_fire && i_item.end_of_stream) |=> r_error_seen)
        else $error("error flag cleared before end of stream");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_fire && i_item.end_of_stream) |=> r_count >= $past(r_count))
        else $error("record counter went backward");

endmodule

### design/fasta_stream_parser_top.sv
// A result is registered in the result register, or in the skid entry while
// that register is stalled. Throughput: one byte per cycle while o_in_stall
// is low; fsp_core's flag and record-counter update loop has combinational
// next-state logic. A two-entry output stage (result register plus skid)
// holds one extra result during output stall; input stall is registered.
// Reset clears all flags, the record counter and both output entries.
module fasta_stream_parser_top #(
    parameter int RECORD_COUNT_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fsp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fsp_pkg::t_out_item o_out_item
);

    logic               r_out_valid;
    fsp_pkg::t_out_item r_out;
    logic               r_skid_valid;
    fsp_pkg::t_out_item r_skid;

    logic               in_fire;
    logic               out_fire;
    fsp_pkg::t_out_item result;

    assign o_in_stall  = r_skid_valid;
    assign in_fire     = i_in_valid && !r_skid_valid;
    assign out_fire    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    fsp_core #(
        .RECORD_COUNT_BITS(RECORD_COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_item   (i_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // drain skid into the result register
                if (out_fire) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_fire) begin
                if (!r_out_valid || out_fire) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= result;
            end else begin
                r_skid <= result;
            end
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty result register");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid)
        else $error("stalled result dropped");

    a_out_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !r_skid_valid && !in_fire |=> !r_out_valid)
        else $error("result repeated after delivery");

    a_skid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_out_stall |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost while output stalled");

endmodule
